[rtl/core/y2b_pkg.sv]
package y2b_pkg;

  // Default frame bounds
  localparam int MAX_WIDTH_DEF  = 512;
  localparam int MAX_HEIGHT_DEF = 256;

  // Upper bounds of the address fields for the largest legal geometry
  localparam int LUMA_ADDR_W_MAX   = 22;
  localparam int CHROMA_ADDR_W_MAX = 20;

  // Configuration register reset values
  localparam int RESET_FRAME_WIDTH  = 320;
  localparam int RESET_FRAME_HEIGHT = 180;

  // Configuration port
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 10;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

  // Queue depths
  localparam int OP_FIFO_DEPTH  = 4;
  localparam int OUT_FIFO_DEPTH = 4;

  // Q12 conversion coefficients
  localparam logic signed [13:0] K_RV = 14'sd5765;
  localparam logic signed [13:0] K_GU = 14'sd1415;
  localparam logic signed [13:0] K_GV = 14'sd2936;
  localparam logic signed [13:0] K_BU = 14'sd7287;
  localparam int PROD_W = 23;
  localparam int ACC_W  = 25;

  // Command codes
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_READ = 1'b1;

  typedef struct packed {
    logic       command;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic       last_pixel;
    logic       not_ready;
  } out_item_t;

  typedef enum logic [2:0] {
    OP_LOAD_Y,
    OP_LOAD_U,
    OP_LOAD_V,
    OP_READ,
    OP_NOT_READY
  } op_kind_e;

  typedef struct packed {
    op_kind_e                       kind;
    logic [LUMA_ADDR_W_MAX-1:0]     luma_addr;
    logic [CHROMA_ADDR_W_MAX-1:0]   chroma_addr;
    logic [7:0]                     data;
    logic                           last;
  } op_t;

  // Effective dimension: even, at least 2, at most the (even) maximum
  function automatic int eff_dim(input int raw, input int maxv);
    int d;
    d = raw & ~1;
    if (d < 2) d = 2;
    if (d > maxv) d = maxv;
    return d;
  endfunction

  // Floor of a Q12 value, saturated to 0..255
  function automatic logic [7:0] clamp_q12(input logic signed [ACC_W-1:0] acc);
    logic [7:0] v;
    if (acc < 0) v = 8'd0;
    else if (acc[ACC_W-2:20] != '0) v = 8'hFF;
    else v = acc[19:12];
    return v;
  endfunction

endpackage

[rtl/core/y2b_fifo.sv]
module y2b_fifo #(
  parameter int Width = 8,
  parameter int Depth = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  output logic             full_o,
  input  logic [Width-1:0] data_i,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [Width-1:0] data_o,
  output logic [$clog2(Depth):0] count_o
);

  localparam int AW = $clog2(Depth);

  logic [Width-1:0] mem_q [Depth];
  logic [AW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [AW:0]      count_q;
  logic             do_push, do_pop;

  assign full_o  = (count_q == (AW+1)'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];
  assign count_o = count_q;

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (do_pop) rd_ptr_q <= rd_ptr_q + 1'b1;
      if (do_push && !do_pop) count_q <= count_q + 1'b1;
      else if (!do_push && do_pop) count_q <= count_q - 1'b1;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= data_i;
  end

endmodule

[rtl/core/y2b_front.sv]
module y2b_front import y2b_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push,
  output logic                   full,
  input  in_item_t               in_item_i,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  output logic                   op_push_o,
  input  logic                   op_full_i,
  output op_t                    op_o
);

  localparam int GeoMaxW     = (MAX_WIDTH / 2) * 2;
  localparam int GeoMaxH     = (MAX_HEIGHT / 2) * 2;
  localparam int LumaDepth   = GeoMaxW * GeoMaxH;
  localparam int ChromaDepth = LumaDepth / 4;
  localparam int LumaAw      = $clog2(LumaDepth);
  localparam int ChromaAw    = (ChromaDepth > 1) ? $clog2(ChromaDepth) : 1;
  localparam int WidthW      = $clog2(GeoMaxW + 1);
  localparam int HeightW     = $clog2(GeoMaxH + 1);
  localparam int ProdW       = WidthW + HeightW;
  localparam int ResetW      = eff_dim(RESET_FRAME_WIDTH, GeoMaxW);
  localparam int ResetH      = eff_dim(RESET_FRAME_HEIGHT, GeoMaxH);

  typedef enum logic [1:0] {
    PLANE_Y,
    PLANE_U,
    PLANE_V
  } plane_e;

  // Configuration and derived geometry
  logic [9:0]          frame_width_q, frame_width_d;
  logic [8:0]          frame_height_q, frame_height_d;
  logic [WidthW-1:0]   w_q, w_d;
  logic [HeightW-1:0]  h_d;
  logic [ProdW-1:0]    ysize, csize;
  logic [LumaAw-1:0]   ysize_m1_q, ysize_m1_d;
  logic [ChromaAw-1:0] csize_m1_q, csize_m1_d;

  // Load and read positions
  plane_e              plane_q;
  logic [LumaAw-1:0]   load_cnt_q;
  logic                complete_q;
  logic [LumaAw-1:0]   rd_pos_q;
  logic [WidthW-1:0]   col_q;
  logic                row_odd_q;
  logic [ChromaAw-1:0] cbase_q;
  logic [ChromaAw-1:0] ci;

  logic hit_w, hit_h, cfg_hit, accept, is_load, last_rd, load_end;

  assign cfg_ready_o = 1'b1;
  assign hit_w   = cfg_valid_i && (cfg_index_i == REG_FRAME_WIDTH);
  assign hit_h   = cfg_valid_i && (cfg_index_i == REG_FRAME_HEIGHT);
  assign cfg_hit = hit_w || hit_h;

  assign full    = op_full_i;
  assign accept  = push && !full;
  assign is_load = (in_item_i.command == CMD_LOAD);

  // Next geometry follows the register values after this cycle's write
  always_comb begin
    frame_width_d  = hit_w ? cfg_data_i : frame_width_q;
    frame_height_d = hit_h ? cfg_data_i[8:0] : frame_height_q;
    w_d   = WidthW'(eff_dim(int'(frame_width_d), GeoMaxW));
    h_d   = HeightW'(eff_dim(int'(frame_height_d), GeoMaxH));
    ysize = ProdW'(w_d) * ProdW'(h_d);
    csize = ProdW'(w_d >> 1) * ProdW'(h_d >> 1);
    ysize_m1_d = LumaAw'(ysize - 1'b1);
    csize_m1_d = ChromaAw'(csize - 1'b1);
  end

  assign ci      = ChromaAw'(cbase_q + ChromaAw'(col_q >> 1));
  assign last_rd = (rd_pos_q == ysize_m1_q);

  always_comb begin
    case (plane_q)
      PLANE_Y: load_end = (load_cnt_q == ysize_m1_q);
      PLANE_U, PLANE_V: load_end = (load_cnt_q == LumaAw'(csize_m1_q));
      default: load_end = 1'b1;
    endcase
  end

  // Classify the accepted item into an operation for the back end
  always_comb begin
    op_o = '0;
    op_o.kind = OP_NOT_READY;
    op_o.data = in_item_i.data_byte;
    op_o.luma_addr = LUMA_ADDR_W_MAX'(load_cnt_q);
    op_o.chroma_addr = CHROMA_ADDR_W_MAX'(load_cnt_q[ChromaAw-1:0]);
    op_push_o = accept && !(is_load && complete_q);
    if (is_load) begin
      case (plane_q)
        PLANE_Y: op_o.kind = OP_LOAD_Y;
        PLANE_U: op_o.kind = OP_LOAD_U;
        PLANE_V: op_o.kind = OP_LOAD_V;
        default: op_o.kind = OP_LOAD_Y;
      endcase
    end else if (complete_q) begin
      op_o.kind = OP_READ;
      op_o.luma_addr = LUMA_ADDR_W_MAX'(rd_pos_q);
      op_o.chroma_addr = CHROMA_ADDR_W_MAX'(ci);
      op_o.last = last_rd;
    end
  end

  // Configuration, geometry and position state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= 10'(RESET_FRAME_WIDTH);
      frame_height_q <= 9'(RESET_FRAME_HEIGHT);
      w_q        <= WidthW'(ResetW);
      ysize_m1_q <= LumaAw'(ResetW * ResetH - 1);
      csize_m1_q <= ChromaAw'((ResetW / 2) * (ResetH / 2) - 1);
      plane_q    <= PLANE_Y;
      load_cnt_q <= '0;
      complete_q <= 1'b0;
      rd_pos_q   <= '0;
      col_q      <= '0;
      row_odd_q  <= 1'b0;
      cbase_q    <= '0;
    end else begin
      frame_width_q  <= frame_width_d;
      frame_height_q <= frame_height_d;
      w_q        <= w_d;
      ysize_m1_q <= ysize_m1_d;
      csize_m1_q <= csize_m1_d;
      if (cfg_hit) begin
        // a write to the frame width or frame height register abandons the frame in progress
        plane_q    <= PLANE_Y;
        load_cnt_q <= '0;
        complete_q <= 1'b0;
        rd_pos_q   <= '0;
        col_q      <= '0;
        row_odd_q  <= 1'b0;
        cbase_q    <= '0;
      end else if (accept && is_load && !complete_q) begin
        if (load_end) begin
          load_cnt_q <= '0;
          case (plane_q)
            PLANE_Y: plane_q <= PLANE_U;
            PLANE_U: plane_q <= PLANE_V;
            PLANE_V: begin
              plane_q    <= PLANE_Y;
              complete_q <= 1'b1;
            end
            default: plane_q <= PLANE_Y;
          endcase
        end else begin
          load_cnt_q <= load_cnt_q + 1'b1;
        end
      end else if (accept && !is_load && complete_q) begin
        if (last_rd) begin
          rd_pos_q   <= '0;
          col_q      <= '0;
          row_odd_q  <= 1'b0;
          cbase_q    <= '0;
          complete_q <= 1'b0;
        end else begin
          rd_pos_q <= rd_pos_q + 1'b1;
          if (col_q == WidthW'(w_q - 1'b1)) begin
            col_q     <= '0;
            row_odd_q <= !row_odd_q;
            // chroma row advances after every second luma row
            if (row_odd_q) cbase_q <= ChromaAw'(cbase_q + ChromaAw'(w_q >> 1));
          end else begin
            col_q <= col_q + 1'b1;
          end
        end
      end
    end
  end

endmodule

[rtl/core/y2b_back.sv]
module y2b_back import y2b_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      op_empty_i,
  output logic      op_pop_o,
  input  op_t       op_i,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_item_o
);

  localparam int GeoMaxW     = (MAX_WIDTH / 2) * 2;
  localparam int GeoMaxH     = (MAX_HEIGHT / 2) * 2;
  localparam int LumaDepth   = GeoMaxW * GeoMaxH;
  localparam int ChromaDepth = LumaDepth / 4;
  localparam int LumaAw      = $clog2(LumaDepth);
  localparam int ChromaAw    = (ChromaDepth > 1) ? $clog2(ChromaDepth) : 1;
  localparam int OutCntW     = $clog2(OUT_FIFO_DEPTH) + 1;

  // Plane stores
  logic [7:0] luma_mem [LumaDepth];
  logic [7:0] cb_mem   [ChromaDepth];
  logic [7:0] cr_mem   [ChromaDepth];
  logic [7:0] luma_rd_q, cb_rd_q, cr_rd_q;

  logic [LumaAw-1:0]   luma_addr;
  logic [ChromaAw-1:0] chroma_addr;
  logic [OutCntW-1:0]  out_count;
  logic [OutCntW:0]    pending;
  logic                take, is_result;

  // Stage 1: store read data, stage 2: products
  logic s1_valid_q, s1_nr_q, s1_last_q;
  logic s2_valid_q, s2_nr_q, s2_last_q;
  logic [7:0] y_q;
  logic signed [PROD_W-1:0] p_bu_q, p_gu_q, p_gv_q, p_rv_q;
  logic signed [8:0] du, dv;
  logic signed [PROD_W-1:0] du_x, dv_x;

  logic signed [ACC_W-1:0] y_ext, acc_b, acc_g, acc_r;
  out_item_t out_d;

  assign luma_addr   = op_i.luma_addr[LumaAw-1:0];
  assign chroma_addr = op_i.chroma_addr[ChromaAw-1:0];

  // Take an operation only when the output queue has room for all results in flight
  assign pending   = (OutCntW+1)'(out_count) + (OutCntW+1)'(s1_valid_q)
                   + (OutCntW+1)'(s2_valid_q);
  assign op_pop_o  = !op_empty_i && (pending < (OutCntW+1)'(OUT_FIFO_DEPTH));
  assign take      = op_pop_o;
  assign is_result = (op_i.kind == OP_READ) || (op_i.kind == OP_NOT_READY);

  // Store write and registered read
  always_ff @(posedge clk_i) begin
    if (take && op_i.kind == OP_LOAD_Y) luma_mem[luma_addr] <= op_i.data;
    luma_rd_q <= luma_mem[luma_addr];
  end

  always_ff @(posedge clk_i) begin
    if (take && op_i.kind == OP_LOAD_U) cb_mem[chroma_addr] <= op_i.data;
    cb_rd_q <= cb_mem[chroma_addr];
  end

  always_ff @(posedge clk_i) begin
    if (take && op_i.kind == OP_LOAD_V) cr_mem[chroma_addr] <= op_i.data;
    cr_rd_q <= cr_mem[chroma_addr];
  end

  // Pipeline control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= take && is_result;
      s2_valid_q <= s1_valid_q;
    end
  end

  assign du = $signed({1'b0, cb_rd_q}) - 9'sd128;
  assign dv = $signed({1'b0, cr_rd_q}) - 9'sd128;

  // Chroma offsets sign-extended to the product width
  assign du_x = PROD_W'(du);
  assign dv_x = PROD_W'(dv);

  // Pipeline payload
  always_ff @(posedge clk_i) begin
    s1_nr_q   <= (op_i.kind == OP_NOT_READY);
    s1_last_q <= op_i.last;
    s2_nr_q   <= s1_nr_q;
    s2_last_q <= s1_last_q;
    y_q       <= luma_rd_q;
    p_bu_q    <= du_x * PROD_W'(K_BU);
    p_gu_q    <= du_x * PROD_W'(K_GU);
    p_gv_q    <= dv_x * PROD_W'(K_GV);
    p_rv_q    <= dv_x * PROD_W'(K_RV);
  end

  // Sum, floor and saturate
  always_comb begin
    y_ext = $signed({5'b0, y_q, 12'b0});
    acc_b = y_ext + ACC_W'(p_bu_q);
    acc_g = y_ext - ACC_W'(p_gu_q) - ACC_W'(p_gv_q);
    acc_r = y_ext + ACC_W'(p_rv_q);
    out_d = '0;
    if (s2_nr_q) begin
      out_d.not_ready = 1'b1;
    end else begin
      out_d.blue       = clamp_q12(acc_b);
      out_d.green      = clamp_q12(acc_g);
      out_d.red        = clamp_q12(acc_r);
      out_d.last_pixel = s2_last_q;
    end
  end

  // Result queue
  y2b_fifo #(
    .Width ($bits(out_item_t)),
    .Depth (OUT_FIFO_DEPTH)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (s2_valid_q),
    .full_o  (),
    .data_i  (out_d),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (out_item_o),
    .count_o (out_count)
  );

endmodule

[rtl/core/yuv420_planar_to_bgr24.sv]
// Channel   Handshake                 Payload
// input     push / full               in_item_i  (command, data_byte)
// result    empty / pop               out_item_o (blue, green, red, last_pixel, not_ready)
// config    cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// One item per cycle is accepted while the operation queue has room; each plane
// store has a single port, and its read and the coefficient multiply take one
// stage each, so a read result leaves the operation queue and passes the read and
// multiply stages before it reaches the result queue. Results back up into the
// 4-entry result queue and then the operation queue, which raises full. Reset is
// asynchronous, active low; the stores are not cleared. cfg_ready_o is always high.
module yuv420_planar_to_bgr24 import y2b_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push,
  output logic                   full,
  input  in_item_t               in_item_i,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  output logic                   empty,
  input  logic                   pop,
  output out_item_t              out_item_o
);

  logic op_push, op_full, op_pop, op_empty;
  op_t  op_in, op_out;

  y2b_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_item_i   (in_item_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .op_push_o   (op_push),
    .op_full_i   (op_full),
    .op_o        (op_in)
  );

  // Operation queue between front and back
  y2b_fifo #(
    .Width ($bits(op_t)),
    .Depth (OP_FIFO_DEPTH)
  ) u_op_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (op_push),
    .full_o  (op_full),
    .data_i  (op_in),
    .pop_i   (op_pop),
    .empty_o (op_empty),
    .data_o  (op_out),
    .count_o ()
  );

  y2b_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_empty_i (op_empty),
    .op_pop_o   (op_pop),
    .op_i       (op_out),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item_o)
  );

endmodule

[rtl/core/y2b_checker.sv]
module y2b_checker import y2b_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      full,
  input logic      empty,
  input logic      pop,
  input out_item_t out_item_o
);

  // Not-ready results carry no color and never mark the last pixel
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_item_o.not_ready) |->
      (out_item_o.blue == 8'd0 && out_item_o.green == 8'd0 &&
       out_item_o.red == 8'd0 && !out_item_o.last_pixel))
    else $error("not_ready result with nonzero fields");

  // A waiting result is not withdrawn before it is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> !empty)
    else $error("result dropped without pop");

  // Nothing waits on the result side right after reset
  assert property (@(posedge clk_i) !rst_ni |=> empty)
    else $error("result visible after reset");

  // The input side is open right after reset
  assert property (@(posedge clk_i) !rst_ni |=> !full)
    else $error("full raised after reset");

endmodule

bind yuv420_planar_to_bgr24 y2b_checker u_y2b_checker (.*);
